@@ src/clf_pkg.sv @@
package clf_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;

  localparam int FIELD_POS_BITS  = 16;
  localparam int FIELD_NAME_BITS = 8;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic [7:0]                data_byte;
    logic [FIELD_POS_BITS-1:0] start_position;
  } in_t;

  typedef struct packed {
    logic [FIELD_POS_BITS-1:0]  frame_start;
    logic [FIELD_POS_BITS-1:0]  frame_length;
    logic [FIELD_NAME_BITS-1:0] name_length;
  } out_t;

  typedef struct packed {
    logic blank;
    logic term;
    logic sep;
    logic open;
    logic close;
  } class_t;

endpackage

@@ src/clf_classify.sv @@
module clf_classify import clf_pkg::*; (
  input  logic [7:0] data_byte,
  output class_t     cls
);

  always_comb begin
    cls.blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB) || (data_byte == CH_CR);
    cls.term  = (data_byte == CH_LF) || (data_byte == CH_NUL);
    cls.sep   = (data_byte == CH_COMMA) || (data_byte == CH_SEMI);
    cls.open  = (data_byte == CH_OPEN);
    cls.close = (data_byte == CH_CLOSE);
  end

endmodule

@@ src/clf_scan.sv @@
module clf_scan import clf_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   step,
  input  in_t    item,
  output logic   emit,
  output out_t   result
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_NAME    = 2'd1;
  localparam logic [1:0] PH_BRACKET = 2'd2;
  localparam logic [1:0] PH_BLANK   = 2'd3;

  localparam int WIDE_BITS = (POSITION_BITS > FIELD_POS_BITS) ? POSITION_BITS : FIELD_POS_BITS;

  logic [1:0]               phase, phase_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] command_start, command_start_next;
  logic [7:0]               name_len_held, name_len_held_next;

  class_t                   cls;
  logic [1:0]               ph;
  logic [POSITION_BITS-1:0] len;
  logic [POSITION_BITS-1:0] emit_len;
  logic [7:0]               emit_name;
  logic [WIDE_BITS-1:0]     start_wide;
  logic [WIDE_BITS-1:0]     len_wide;

  clf_classify u_classify (
    .data_byte (item.data_byte),
    .cls       (cls)
  );

  always_comb begin
    phase_next         = phase;
    command_start_next = command_start;
    name_len_held_next = name_len_held;
    byte_position_next = byte_position + POSITION_BITS'(1);
    len                = byte_position - command_start;
    ph                 = phase;
    emit               = 1'b0;
    emit_len           = len;
    emit_name          = name_len_held;

    if (item.kind == KIND_RESTART) begin
      byte_position_next = POSITION_BITS'(item.start_position);
      command_start_next = POSITION_BITS'(item.start_position);
      name_len_held_next = '0;
      phase_next         = PH_IDLE;
    end else begin
      // In idle, any byte other than a blank, terminator or separator opens a
      // command and is then treated as a name byte.
      if (ph == PH_IDLE && !(cls.blank || cls.term || cls.sep)) begin
        command_start_next = byte_position;
        name_len_held_next = '0;
        ph                 = PH_NAME;
        phase_next         = PH_NAME;
        len                = '0;
      end
      emit_len  = len;
      emit_name = name_len_held_next;
      case (ph)
        PH_NAME: begin
          if (cls.term || cls.sep) begin
            emit       = 1'b1;
            emit_name  = len[7:0];
            phase_next = PH_IDLE;
          end else if (cls.open) begin
            name_len_held_next = len[7:0];
            phase_next         = PH_BRACKET;
          end else if (cls.blank) begin
            name_len_held_next = len[7:0];
            phase_next         = PH_BLANK;
          end
        end
        PH_BRACKET: begin
          if (cls.term) begin
            emit       = 1'b1;
            phase_next = PH_IDLE;
          end else if (cls.close) begin
            // The closing bracket counts toward the command length.
            emit       = 1'b1;
            emit_len   = len + POSITION_BITS'(1);
            phase_next = PH_IDLE;
          end
        end
        PH_BLANK: begin
          if (cls.term || cls.sep) begin
            emit       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end

    start_wide          = WIDE_BITS'(command_start_next);
    len_wide            = WIDE_BITS'(emit_len);
    result.frame_start  = start_wide[FIELD_POS_BITS-1:0];
    result.frame_length = len_wide[FIELD_POS_BITS-1:0];
    result.name_length  = emit_name;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
      command_start <= '0;
      name_len_held <= '0;
    end else if (step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      command_start <= command_start_next;
      name_len_held <= name_len_held_next;
    end
  end

  a_restart_idle: assert property (@(posedge clk) disable iff (rst)
    step && item.kind == KIND_RESTART |=> phase == PH_IDLE && command_start == byte_position)
    else $error("restart did not return the scanner to idle");

  a_no_emit_on_restart: assert property (@(posedge clk) disable iff (rst)
    item.kind == KIND_RESTART |-> !emit)
    else $error("restart produced a frame");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    step && item.kind == KIND_DATA |=> byte_position == $past(byte_position) + POSITION_BITS'(1))
    else $error("byte position did not advance by one");

  a_emit_returns_idle: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> phase == PH_IDLE)
    else $error("scanner stayed in a command after framing it");

endmodule

@@ src/command_line_framer.sv @@
// Channel   Direction  Handshake                  Payload
// byte      input      byte_valid / byte_ready    byte_item  (in_t)
// frame     output     frame_valid / frame_ready  frame_item (out_t)
//
// One byte per cycle sustained unless a framing byte waits on a stalled frame; each
// item is taken into the input register, and an item that closes a command writes
// its frame to the frame register as it leaves. The scanner state updates as an
// item leaves the input register. Synchronous reset returns the scanner to idle at
// position zero. A stalled frame holds only items that would frame another command;
// other bytes keep flowing.
module command_line_framer import clf_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic byte_valid,
  output logic byte_ready,
  input  in_t  byte_item,
  output logic frame_valid,
  input  logic frame_ready,
  output out_t frame_item
);

  logic hold_valid;
  in_t  hold_item;
  logic emit;
  out_t result;
  logic frame_free;
  logic step;

  assign frame_free = !frame_valid || frame_ready;
  assign step       = hold_valid && (!emit || frame_free);
  assign byte_ready = !hold_valid || step;

  clf_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (hold_item),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_ready) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      hold_item <= byte_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_free) begin
      frame_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      frame_item <= result;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |-> !(step && emit))
    else $error("pending frame overwritten");

  a_emit_stall_holds: assert property (@(posedge clk) disable iff (rst)
    hold_valid && emit && frame_valid && !frame_ready |-> !byte_ready)
    else $error("input taken while a framing byte is stalled");

  a_frame_follows_step: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> frame_valid)
    else $error("framed command did not reach the output");

endmodule

@@ dv/command_line_framer_test.sv @@
module command_line_framer_test import clf_pkg::*;;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NAME,
    SCAN_BRACKET,
    SCAN_BLANK_ARGS
  } scan_phase_t;

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t frame;
  } step_row_t;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_NAME_CMD = 3;
  localparam int PHASE_ITEMS   = 100;

  logic clk = 1'b0;
  logic rst;
  logic byte_valid;
  logic byte_ready;
  in_t  byte_item;
  logic frame_valid;
  logic frame_ready = 1'b0;
  out_t frame_item;

  // Shadow of the scanner state.
  scan_phase_t scan_phase    = SCAN_IDLE;
  logic [15:0] shadow_pos    = '0;
  logic [15:0] cmd_begin     = '0;
  logic [7:0]  held_name_len = '0;

  out_t      frames_due[$];
  out_t      want_frame;
  step_row_t dir_rows[$];
  int        errors = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  always #5 clk = ~clk;

  command_line_framer dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .frame_item (frame_item)
  );

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR;
  endfunction

  function automatic bit is_term(input logic [7:0] c);
    return c == CH_LF || c == CH_NUL;
  endfunction

  function automatic bit is_sep(input logic [7:0] c);
    return c == CH_COMMA || c == CH_SEMI;
  endfunction

  // Advances the shadow scanner by one item; returns 1 when the item closes a command.
  function automatic bit next_frame(input in_t it, output out_t fr);
    logic [7:0]  c;
    logic [15:0] len;
    bit          done;
    c    = it.data_byte;
    len  = shadow_pos - cmd_begin;
    done = 1'b0;
    fr   = '0;
    if (it.kind == KIND_RESTART) begin
      shadow_pos    = it.start_position;
      cmd_begin     = it.start_position;
      held_name_len = '0;
      scan_phase    = SCAN_IDLE;
      return 1'b0;
    end
    if (scan_phase == SCAN_IDLE && !(is_blank(c) || is_term(c) || is_sep(c))) begin
      cmd_begin     = shadow_pos;
      held_name_len = '0;
      scan_phase    = SCAN_NAME;
      len           = '0;
    end
    case (scan_phase)
      SCAN_NAME: begin
        if (is_term(c) || is_sep(c)) begin
          fr   = {cmd_begin, len, len[7:0]};
          done = 1'b1;
        end else if (c == CH_OPEN) begin
          held_name_len = len[7:0];
          scan_phase    = SCAN_BRACKET;
        end else if (is_blank(c)) begin
          held_name_len = len[7:0];
          scan_phase    = SCAN_BLANK_ARGS;
        end
      end
      SCAN_BRACKET: begin
        if (is_term(c)) begin
          fr   = {cmd_begin, len, held_name_len};
          done = 1'b1;
        end else if (c == CH_CLOSE) begin
          // The closing bracket counts toward the length.
          fr   = {cmd_begin, len + 16'd1, held_name_len};
          done = 1'b1;
        end
      end
      SCAN_BLANK_ARGS: begin
        if (is_term(c) || is_sep(c)) begin
          fr   = {cmd_begin, len, held_name_len};
          done = 1'b1;
        end
      end
      default: ;
    endcase
    if (done) scan_phase = SCAN_IDLE;
    shadow_pos = shadow_pos + 16'd1;
    return done;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_end(input bit seps_too);
    case (seps_too ? $urandom_range(3) : $urandom_range(1))
      0: return CH_LF;
      1: return CH_NUL;
      2: return CH_COMMA;
      default: return CH_SEMI;
    endcase
  endfunction

  function automatic logic [7:0] pick_name_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (is_blank(c) || is_term(c) || is_sep(c) || c == CH_OPEN);
    return c;
  endfunction

  function automatic logic [7:0] pick_arg_char(input bit bracketed);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (is_term(c) || (bracketed ? c == CH_CLOSE : is_sep(c)));
    return c;
  endfunction

  function automatic void add_row(input logic kind, input logic [7:0] b,
                                  input logic [15:0] p, input logic typed,
                                  input out_t fr);
    step_row_t row;
    row.item  = {kind, b, p};
    row.typed = typed;
    row.frame = fr;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    add_row(KIND_DATA, b, 16'($urandom_range(65535)), 1'b0, '0);
  endfunction

  function automatic void add_frame_byte(input logic [7:0] b, input logic [15:0] start,
                                         input logic [15:0] len, input logic [7:0] nlen);
    add_row(KIND_DATA, b, 16'($urandom_range(65535)), 1'b1, {start, len, nlen});
  endfunction

  function automatic void add_restart(input logic [15:0] p);
    add_row(KIND_RESTART, 8'($urandom_range(255)), p, 1'b0, '0);
  endfunction

  // Offers one item, waits for its transfer, then books the frame it should cause.
  task automatic send_item(input in_t it, input logic typed, input out_t typed_frame);
    out_t fr;
    bit   got;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    do @(posedge clk); while (!byte_ready);
    got = next_frame(it, fr);
    if (typed) frames_due.push_back(typed_frame);
    else if (got) frames_due.push_back(fr);
  endtask

  task automatic send_data(input logic [7:0] b);
    in_t it;
    it.kind           = KIND_DATA;
    it.data_byte      = b;
    it.start_position = 16'($urandom_range(65535));
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_restart(input logic [15:0] p);
    in_t it;
    it.kind           = KIND_RESTART;
    it.data_byte      = 8'($urandom_range(255));
    it.start_position = p;
    send_item(it, 1'b0, '0);
  endtask

  task automatic drain_frames();
    byte_valid <= 1'b0;
    do @(posedge clk); while (frames_due.size() != 0);
  endtask

  // Mostly well-formed commands with random content, plus stray bytes and restarts.
  task automatic run_random(input int quota, input bit with_long_name);
    int          sent;
    int          cmd_no;
    int          name_len;
    int          arg_len;
    int          ending;
    int          pick;
    logic [15:0] p;
    sent   = 0;
    cmd_no = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        p = 16'($urandom_range(65535));
        // Land close to the top of the range half the time so positions wrap.
        if ($urandom_range(1)) p[15:4] = '1;
        send_restart(p);
        sent++;
      end else if (pick < 12) begin
        send_data(8'($urandom_range(255)));
        sent++;
      end else begin
        repeat ($urandom_range(2)) send_data($urandom_range(1) ? pick_blank() : pick_end(1'b1));
        ending   = $urandom_range(2);
        name_len = (with_long_name && cmd_no == LONG_NAME_CMD) ? $urandom_range(256, 300) :
                                                                 $urandom_range(1, 6);
        if (ending == 1 && $urandom_range(7) == 0) name_len = 0;
        arg_len = $urandom_range(5);
        repeat (name_len) send_data(pick_name_char());
        case (ending)
          0: send_data(pick_end(1'b1));
          1: begin
            send_data(CH_OPEN);
            repeat (arg_len) send_data(pick_arg_char(1'b1));
            send_data($urandom_range(3) ? CH_CLOSE : pick_end(1'b0));
          end
          default: begin
            send_data(pick_blank());
            repeat (arg_len) send_data(pick_arg_char(1'b0));
            send_data(pick_end(1'b1));
          end
        endcase
        sent += name_len + 1 + (ending != 0 ? arg_len + 1 : 0);
        cmd_no++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && frame_valid && frame_ready) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame: start %h length %h name %h", $time,
                 frame_item.frame_start, frame_item.frame_length, frame_item.name_length);
        errors++;
      end else begin
        want_frame = frames_due.pop_front();
        if (frame_item.frame_start !== want_frame.frame_start ||
            frame_item.frame_length !== want_frame.frame_length ||
            frame_item.name_length !== want_frame.name_length) begin
          $display("%0t: frame mismatch: expected start %h length %h name %h, got %h %h %h",
                   $time, want_frame.frame_start, want_frame.frame_length,
                   want_frame.name_length, frame_item.frame_start,
                   frame_item.frame_length, frame_item.name_length);
          errors++;
        end
      end
    end
    frame_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d frames outstanding", frames_due.size());
      $display("command_line_framer_test: FAIL");
      $finish;
    end
  end

  initial begin
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    byte_item  <= '0;
    send_idle_pct = 6;
    recv_idle_pct = 81;

    // Bare command, then skipped blanks and terminators.
    add_byte("A");
    add_frame_byte(CH_COMMA, 16'd0, 16'd1, 8'd1);
    add_byte(CH_SPACE);
    add_byte(CH_CR);
    add_byte(CH_LF);
    // Bracketed arguments closed by ')', then a separator the idle scanner drops.
    add_byte("f");
    add_byte(CH_OPEN);
    add_byte("x");
    add_frame_byte(CH_CLOSE, 16'd5, 16'd4, 8'd1);
    add_byte(CH_SEMI);
    // Blank-separated arguments.
    add_byte("g");
    add_byte(CH_SPACE);
    add_byte("a");
    add_frame_byte(CH_SEMI, 16'd10, 16'd3, 8'd1);
    // An open bracket first gives an empty name.
    add_byte(CH_OPEN);
    add_frame_byte(CH_LF, 16'd14, 16'd1, 8'd0);
    // Command that straddles the position wrap.
    add_restart(16'hfffe);
    add_byte(8'hff);
    add_byte(8'h80);
    add_frame_byte(CH_NUL, 16'hfffe, 16'd2, 8'd2);
    add_restart(16'h0000);
    add_byte("h");
    add_byte(CH_TAB);
    add_frame_byte(CH_NUL, 16'd0, 16'd2, 8'd1);
    add_restart(16'hffff);
    add_byte("z");
    add_frame_byte(CH_LF, 16'hffff, 16'd1, 8'd1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].frame);
    run_random(PHASE_ITEMS, 1'b1);
    drain_frames();

    send_idle_pct = 81;
    recv_idle_pct = 6;
    run_random(PHASE_ITEMS, 1'b0);
    drain_frames();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS, 1'b0);
    drain_frames();

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("command_line_framer_test: PASS");
    end else begin
      $display("command_line_framer_test: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/clf_pkg.sv
src/clf_classify.sv
src/clf_scan.sv
src/command_line_framer.sv
dv/command_line_framer_test.sv
